### rtl/core/assert_macros.svh
// Assertion helpers used by the checker file hrlc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define CHK_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CHK_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/hrlc_pkg.sv
`default_nettype none

package hrlc_pkg;

    localparam int MAX_LINE_DEF    = 8192;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int NUM_METHODS = 9;
    localparam int OUT_TDATA_W = 40;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_MALFORMED   = 2'd1;
    localparam logic [1:0] ST_BAD_VERSION = 2'd2;
    localparam logic [1:0] ST_BAD_METHOD  = 2'd3;

    // Method codes
    localparam logic [3:0] METH_GET     = 4'd0;
    localparam logic [3:0] METH_HEAD    = 4'd1;
    localparam logic [3:0] METH_POST    = 4'd2;
    localparam logic [3:0] METH_PUT     = 4'd3;
    localparam logic [3:0] METH_DELETE  = 4'd4;
    localparam logic [3:0] METH_CONNECT = 4'd5;
    localparam logic [3:0] METH_OPTIONS = 4'd6;
    localparam logic [3:0] METH_TRACE   = 4'd7;
    localparam logic [3:0] METH_PATCH   = 4'd8;

    // Line parts
    localparam logic [1:0] PART_METHOD  = 2'd0;
    localparam logic [1:0] PART_TARGET  = 2'd1;
    localparam logic [1:0] PART_VERSION = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    // One classified byte on its way from front to back
    typedef struct packed {
        logic       last;
        logic       is_space;
        logic       is_ctl;
        logic       is_digit;
        logic       is_hex;
        logic [7:0] data;
    } t_tok;

    // Result item, last field (status) in the lowest bits
    typedef struct packed {
        logic [12:0] target_length;
        logic [12:0] target_offset;
        logic        version_code;
        logic [3:0]  method_code;
        logic [1:0]  status;
    } t_result;

    function automatic logic [2:0] method_len(input logic [3:0] m);
        unique case (m)
            METH_GET, METH_PUT:                        method_len = 3'd3;
            METH_HEAD, METH_POST:                      method_len = 3'd4;
            METH_TRACE, METH_PATCH:                    method_len = 3'd5;
            METH_DELETE:                               method_len = 3'd6;
            METH_CONNECT, METH_OPTIONS:                method_len = 3'd7;
            default:                                   method_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] method_char(input logic [3:0] m, input logic [2:0] k);
        logic [55:0] nm;
        unique case (m)
            METH_GET:     nm = "GET    ";
            METH_HEAD:    nm = "HEAD   ";
            METH_POST:    nm = "POST   ";
            METH_PUT:     nm = "PUT    ";
            METH_DELETE:  nm = "DELETE ";
            METH_CONNECT: nm = "CONNECT";
            METH_OPTIONS: nm = "OPTIONS";
            METH_TRACE:   nm = "TRACE  ";
            METH_PATCH:   nm = "PATCH  ";
            default:      nm = "       ";
        endcase
        unique case (k)
            3'd0:    method_char = nm[55:48];
            3'd1:    method_char = nm[47:40];
            3'd2:    method_char = nm[39:32];
            3'd3:    method_char = nm[31:24];
            3'd4:    method_char = nm[23:16];
            3'd5:    method_char = nm[15:8];
            3'd6:    method_char = nm[7:0];
            default: method_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] version_char(input logic [2:0] k);
        unique case (k)
            3'd0:    version_char = "H";
            3'd1:    version_char = "T";
            3'd2:    version_char = "T";
            3'd3:    version_char = "P";
            3'd4:    version_char = "/";
            default: version_char = 8'h00;
        endcase
    endfunction

endpackage

`default_nettype wire

### rtl/core/http_request_line_checker_top.sv
// Channel   Dir  Fields (tdata from bit 0 up)
// s_axis    in   tdata: byte_value[7:0]; tlast: last
// m_axis    out  tdata: status[1:0], method_code[5:2], version_code[6],
//                target_offset[19:7], target_length[32:20], zero fill [39:33]
//
// Sustained rate is one byte per cycle while no closing byte waits on an
// output stall: the back end's line-state update retires one byte from the
// QUEUE_DEPTH-entry queue each such cycle. A closing byte is queued, and
// at the head with m_axis free it pops and its result is registered.
// Reset (i_rst_n low, synchronous) empties the queue, clears the line
// state and drops a pending result.
// An output stall blocks the queue only once a closing byte is at its head.
`default_nettype none

module http_request_line_checker_top
    import hrlc_pkg::*;
#(
    parameter int MAX_LINE    = MAX_LINE_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [7:0]             i_s_axis_tdata,  // byte_value
    input  wire logic                   i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // status, method_code, version_code, target_offset, target_length, zero fill
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int PAD_W = OUT_TDATA_W - $bits(t_result);

    logic    q_ready;
    logic    push;
    t_tok    push_tok;
    logic    q_valid;
    t_tok    head_tok;
    logic    pop;
    t_result res;

    hrlc_front u_front (
        .i_tvalid  (i_s_axis_tvalid),
        .i_tdata   (i_s_axis_tdata),
        .i_tlast   (i_s_axis_tlast),
        .o_tready  (o_s_axis_tready),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_tok     (push_tok)
    );

    hrlc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_tok   (head_tok),
        .i_pop   (pop)
    );

    hrlc_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_tok     (head_tok),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .o_res     (res),
        .i_ready   (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, res};

endmodule

`default_nettype wire

### rtl/core/hrlc_front.sv
`default_nettype none

module hrlc_front
    import hrlc_pkg::*;
(
    input  wire logic       i_tvalid,
    input  wire logic [7:0] i_tdata,
    input  wire logic       i_tlast,
    output logic            o_tready,
    input  wire logic       i_q_ready,
    output logic            o_push,
    output t_tok            o_tok
);

    logic is_digit;

    assign is_digit = (i_tdata >= 8'h30) && (i_tdata <= 8'h39);

    assign o_tready = i_q_ready;
    assign o_push   = i_tvalid && i_q_ready;

    always_comb begin
        o_tok.data     = i_tdata;
        o_tok.last     = i_tlast;
        o_tok.is_space = (i_tdata == CH_SPACE);
        o_tok.is_ctl   = (i_tdata < CH_SPACE) || (i_tdata == CH_DEL);
        o_tok.is_digit = is_digit;
        o_tok.is_hex   = is_digit
                      || ((i_tdata >= 8'h41) && (i_tdata <= 8'h46))
                      || ((i_tdata >= 8'h61) && (i_tdata <= 8'h66));
    end

endmodule

`default_nettype wire

### rtl/core/hrlc_queue.sv
`default_nettype none

module hrlc_queue
    import hrlc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_tok      i_tok,
    output logic      o_ready,
    output logic      o_valid,
    output t_tok      o_tok,
    input  wire logic i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_tok            r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_count;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

endmodule

`default_nettype wire

### rtl/core/hrlc_back.sv
`default_nettype none

module hrlc_back
    import hrlc_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  t_tok      i_tok,
    output logic      o_pop,
    output logic      o_valid,
    output t_result   o_res,
    input  wire logic i_ready
);

    localparam int POS_W = $clog2(MAX_LINE + 1);
    localparam int EXT_W = (POS_W > 13) ? POS_W : 13;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LINE);

    localparam int FLAG_CTL   = 0;
    localparam int FLAG_EXTRA = 1;
    localparam int FLAG_EMPTY = 2;

    logic [POS_W-1:0]       r_pos, n_pos;
    logic [1:0]             r_part, n_part;
    logic [NUM_METHODS-1:0] r_cand, n_cand;
    logic [2:0]             r_mlen, n_mlen;
    logic [2:0]             r_flags, n_flags;
    logic [1:0]             r_esc, n_esc;
    logic                   r_esc_bad, n_esc_bad;
    logic [POS_W-1:0]       r_tstart, n_tstart;
    logic [3:0]             r_vidx, n_vidx;
    logic                   r_vshape, n_vshape;
    logic [7:0]             r_vdig, n_vdig;
    logic                   r_over, n_over;

    logic                   r_out_valid;
    t_result                r_out;
    t_result                res;

    logic                   ver_go;
    logic                   good;
    logic [3:0]             meth;
    logic [POS_W-1:0]       len_full;
    logic [EXT_W-1:0]       off_ext;
    logic [EXT_W-1:0]       len_ext;
    logic                   out_free;
    logic                   close_line;

    assign out_free   = !r_out_valid || i_ready;
    assign o_pop      = i_q_valid && (!i_tok.last || out_free);
    assign close_line = o_pop && i_tok.last;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    // Line state update for the byte at the head of the queue
    always_comb begin
        n_pos     = r_pos;
        n_part    = r_part;
        n_cand    = r_cand;
        n_mlen    = r_mlen;
        n_flags   = r_flags;
        n_esc     = r_esc;
        n_esc_bad = r_esc_bad;
        n_tstart  = r_tstart;
        n_vidx    = r_vidx;
        n_vshape  = r_vshape;
        n_vdig    = r_vdig;
        n_over    = r_over;
        ver_go    = 1'b0;

        if (r_pos >= MAX_POS) begin
            n_over = 1'b1;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end

        if (i_tok.is_ctl) begin
            n_flags[FLAG_CTL] = 1'b1;
        end

        if (i_tok.is_space) begin
            case (r_part)
                PART_METHOD: begin
                    if (r_mlen == 3'd0) begin
                        n_flags[FLAG_EMPTY] = 1'b1;
                    end
                    n_tstart = n_pos;
                    n_part   = PART_TARGET;
                end
                PART_TARGET: begin
                    if ((n_pos - POS_W'(1)) <= r_tstart) begin
                        n_flags[FLAG_EMPTY] = 1'b1;
                    end
                    if (r_esc != 2'd0) begin
                        n_esc_bad = 1'b1;
                    end
                    n_esc  = 2'd0;
                    n_part = PART_VERSION;
                end
                default: begin
                    n_flags[FLAG_EXTRA] = 1'b1;
                    ver_go              = 1'b1;
                end
            endcase
        end else begin
            case (r_part)
                PART_METHOD: begin
                    for (int i = 0; i < NUM_METHODS; i++) begin
                        if ((r_mlen >= method_len(4'(i)))
                            || (method_char(4'(i), r_mlen) != i_tok.data)) begin
                            n_cand[i] = 1'b0;
                        end
                    end
                    if (r_mlen != 3'd7) begin
                        n_mlen = r_mlen + 3'd1;
                    end
                end
                PART_TARGET: begin
                    if (r_esc != 2'd0) begin
                        if (!i_tok.is_hex) begin
                            n_esc_bad = 1'b1;
                        end
                        n_esc = r_esc - 2'd1;
                    end else if (i_tok.data == CH_PERCENT) begin
                        n_esc = 2'd2;
                    end
                end
                default: begin
                    ver_go = 1'b1;
                end
            endcase
        end

        if (ver_go) begin
            case (r_vidx) inside
                [4'd0:4'd4]: begin
                    if (i_tok.data != version_char(r_vidx[2:0])) begin
                        n_vshape = 1'b0;
                    end
                end
                4'd5: begin
                    if (i_tok.is_digit) begin
                        n_vdig[7:4] = i_tok.data[3:0];
                    end else begin
                        n_vshape = 1'b0;
                    end
                end
                4'd6: begin
                    if (i_tok.data != CH_DOT) begin
                        n_vshape = 1'b0;
                    end
                end
                4'd7: begin
                    if (i_tok.is_digit) begin
                        n_vdig[3:0] = i_tok.data[3:0];
                    end else begin
                        n_vshape = 1'b0;
                    end
                end
                default: begin
                    n_vshape = 1'b0;
                end
            endcase
            if (r_vidx != 4'd15) begin
                n_vidx = r_vidx + 4'd1;
            end
        end
    end

    // Verdict for a closing byte, taken from the updated line state
    always_comb begin
        good = 1'b0;
        meth = METH_GET;
        for (int i = 0; i < NUM_METHODS; i++) begin
            if (!good && n_cand[i] && (method_len(4'(i)) == n_mlen)) begin
                good = 1'b1;
                meth = 4'(i);
            end
        end

        len_full = n_pos - n_tstart - POS_W'(9);
        off_ext  = EXT_W'(n_tstart);
        len_ext  = EXT_W'(len_full);

        res = '0;
        if (n_over || (n_part != PART_VERSION) || (n_flags != 3'd0) || (n_vidx == 4'd0)) begin
            res.status = ST_MALFORMED;
        end else if (!n_vshape || (n_vidx != 4'd8)) begin
            res.status = ST_MALFORMED;
        end else if ((n_vdig != 8'h10) && (n_vdig != 8'h11)) begin
            res.status = ST_BAD_VERSION;
        end else if (n_esc_bad) begin
            res.status = ST_MALFORMED;
        end else if (!good) begin
            res.status = ST_BAD_METHOD;
        end else begin
            res.status        = ST_OK;
            res.method_code   = meth;
            res.version_code  = (n_vdig == 8'h11);
            res.target_offset = off_ext[12:0];
            res.target_length = len_ext[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || close_line) begin
            r_pos     <= '0;
            r_part    <= PART_METHOD;
            r_cand    <= '1;
            r_mlen    <= '0;
            r_flags   <= '0;
            r_esc     <= '0;
            r_esc_bad <= 1'b0;
            r_tstart  <= '0;
            r_vidx    <= '0;
            r_vshape  <= 1'b1;
            r_vdig    <= '0;
            r_over    <= 1'b0;
        end else if (o_pop) begin
            r_pos     <= n_pos;
            r_part    <= n_part;
            r_cand    <= n_cand;
            r_mlen    <= n_mlen;
            r_flags   <= n_flags;
            r_esc     <= n_esc;
            r_esc_bad <= n_esc_bad;
            r_tstart  <= n_tstart;
            r_vidx    <= n_vidx;
            r_vshape  <= n_vshape;
            r_vdig    <= n_vdig;
            r_over    <= n_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (close_line) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result until the downstream takes it
    always_ff @(posedge i_clk) begin
        if (close_line) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

### rtl/core/hrlc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module hrlc_checker
    import hrlc_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    `CHK_ASSERT(a_stall_hold, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "result changed while stalled")

    `CHK_ASSERT(a_method_range, (o_m_axis_tvalid && (o_m_axis_tdata[1:0] == ST_OK)) |-> (o_m_axis_tdata[5:2] <= METH_PATCH), "method code out of range")

    `CHK_ASSERT(a_fail_zero, (o_m_axis_tvalid && (o_m_axis_tdata[1:0] != ST_OK)) |-> (o_m_axis_tdata[OUT_TDATA_W-1:2] == '0), "failed result carries nonzero fields")

    `CHK_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

bind http_request_line_checker_top hrlc_checker u_hrlc_checker (.*);

`default_nettype wire

### test/tb_http_request_line_checker_top.sv
`default_nettype none

module tb_http_request_line_checker_top;
    import hrlc_pkg::*;

    localparam int RANDOM_BYTES  = 1000;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT_RESULT = 30;
    localparam int DRAIN_AT_LINE = 15;

    // malformed flag bits
    localparam int FLAG_CTL_BIT   = 0;
    localparam int FLAG_SPACE_BIT = 1;
    localparam int FLAG_EMPTY_BIT = 2;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;  // wait for every result before offering this byte
    } t_line_byte;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [7:0]             i_s_axis_tdata = '0;  // byte_value
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // status, method_code, version_code, target_offset, target_length, zero fill
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    http_request_line_checker_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // indexed by method code
    string verb_name[NUM_METHODS] = '{"GET", "HEAD", "POST", "PUT", "DELETE",
                                      "CONNECT", "OPTIONS", "TRACE", "PATCH"};
    string version_prefix = "HTTP/";
    string hex_chars      = "0123456789abcdefABCDEF";
    string version_junk   = "HTTP/1.0 2x%";

    t_line_byte  line_bytes[$];
    logic [7:0]  line_buf[$];
    t_result     line_results[$];

    int n_errors  = 0;
    int n_results = 0;
    bit in_fire   = 1'b0;
    bit out_fire  = 1'b0;
    int tx_gap    = 0;
    bit tx_burst  = 1'b0;
    int rx_wait   = 0;
    bit rx_burst  = 1'b0;

    // line state of the parser being predicted
    int         rl_pos;
    logic [1:0] rl_part;
    logic [8:0] verb_mask;
    int         verb_len;
    logic [3:0] rl_flags;
    int         pct_owed;
    bit         pct_bad;
    int         tgt_start;
    int         ver_len;
    bit         ver_shape_ok;
    logic [7:0] ver_digits;
    bit         rl_overlong;

    function automatic void clear_request_line();
        rl_pos       = 0;
        rl_part      = PART_METHOD;
        verb_mask    = '1;
        verb_len     = 0;
        rl_flags     = '0;
        pct_owed     = 0;
        pct_bad      = 1'b0;
        tgt_start    = 0;
        ver_len      = 0;
        ver_shape_ok = 1'b1;
        ver_digits   = '0;
        rl_overlong  = 1'b0;
    endfunction

    // Advance the line state by one byte; return 1 with the result on the closing byte.
    function automatic bit step_request_line(input logic [7:0] b, input logic last,
                                             output t_result r);
        bit         is_dig;
        bit         is_hx;
        bit         good;
        logic [3:0] code;
        int         i;
        is_dig = (b >= "0" && b <= "9");
        is_hx  = is_dig || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
        good   = 1'b0;
        code   = METH_GET;
        r      = '0;

        if (rl_pos >= MAX_LINE_DEF) rl_overlong = 1'b1;
        else rl_pos++;
        if (b < CH_SPACE || b == CH_DEL) rl_flags[FLAG_CTL_BIT] = 1'b1;

        case (rl_part)
            PART_METHOD: begin
                if (b == CH_SPACE) begin
                    if (verb_len == 0) rl_flags[FLAG_EMPTY_BIT] = 1'b1;
                    tgt_start = rl_pos;
                    rl_part   = PART_TARGET;
                end else begin
                    for (i = 0; i < NUM_METHODS; i++) begin
                        if (verb_len >= verb_name[i].len() || verb_name[i][verb_len] != b)
                            verb_mask[i] = 1'b0;
                    end
                    if (verb_len < 7) verb_len++;
                end
            end
            PART_TARGET: begin
                if (b == CH_SPACE) begin
                    if (rl_pos - 1 <= tgt_start) rl_flags[FLAG_EMPTY_BIT] = 1'b1;
                    if (pct_owed != 0) pct_bad = 1'b1;
                    pct_owed = 0;
                    rl_part  = PART_VERSION;
                end else if (pct_owed != 0) begin
                    if (!is_hx) pct_bad = 1'b1;
                    pct_owed--;
                end else if (b == CH_PERCENT) begin
                    pct_owed = 2;
                end
            end
            default: begin
                // spaces past the second one still count as version bytes
                if (b == CH_SPACE) rl_flags[FLAG_SPACE_BIT] = 1'b1;
                if (ver_len < 5) begin
                    if (b != version_prefix[ver_len]) ver_shape_ok = 1'b0;
                end else if (ver_len == 5) begin
                    if (is_dig) ver_digits[7:4] = b[3:0];
                    else ver_shape_ok = 1'b0;
                end else if (ver_len == 6) begin
                    if (b != CH_DOT) ver_shape_ok = 1'b0;
                end else if (ver_len == 7) begin
                    if (is_dig) ver_digits[3:0] = b[3:0];
                    else ver_shape_ok = 1'b0;
                end else begin
                    ver_shape_ok = 1'b0;
                end
                if (ver_len < 15) ver_len++;
            end
        endcase

        if (!last) return 1'b0;

        for (i = 0; i < NUM_METHODS; i++) begin
            if (!good && verb_mask[i] && verb_name[i].len() == verb_len) begin
                good = 1'b1;
                code = 4'(i);
            end
        end

        if (rl_overlong || rl_part != PART_VERSION || rl_flags != 0 || ver_len == 0)
            r.status = ST_MALFORMED;
        else if (!ver_shape_ok || ver_len != 8)
            r.status = ST_MALFORMED;
        else if (ver_digits != 8'h10 && ver_digits != 8'h11)
            r.status = ST_BAD_VERSION;
        else if (pct_bad)
            r.status = ST_MALFORMED;
        else if (!good)
            r.status = ST_BAD_METHOD;
        else begin
            r.status        = ST_OK;
            r.method_code   = code;
            r.version_code  = (ver_digits == 8'h11);
            r.target_offset = 13'(tgt_start);
            r.target_length = (rl_pos >= tgt_start + 9) ? 13'(rl_pos - tgt_start - 9) : '0;
        end
        clear_request_line();
        return 1'b1;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endtask

    task automatic append_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic flush_line(input bit drain);
        t_line_byte it;
        int         i;
        for (i = 0; i < line_buf.size(); i++) begin
            it.data  = line_buf[i];
            it.last  = (i == line_buf.size() - 1);
            it.drain = drain && (i == 0);
            line_bytes = {line_bytes, it};
        end
        line_buf.delete();
    endtask

    // Mostly well-formed request lines with random content, some mutated, some noise.
    task automatic queue_random_line(input bit drain);
        int k;
        int n;
        int pos;
        if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(1, 24);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end else begin
            k = $urandom_range(0, 11);
            if (k < NUM_METHODS) begin
                append_text(verb_name[k]);
            end else if (k == 9) begin
                n = $urandom_range(0, 9);
                repeat (n) put_byte(8'($urandom_range(8'h41, 8'h5A)));
            end else if (k == 10) begin
                n = $urandom_range(0, NUM_METHODS - 1);
                append_text(verb_name[n].substr(0, verb_name[n].len() - 2));
            end else begin
                append_text(verb_name[$urandom_range(0, NUM_METHODS - 1)]);
                put_byte(8'($urandom_range(8'h41, 8'h5A)));
            end
            put_byte(CH_SPACE);

            if ($urandom_range(0, 15) != 0) append_text("/");
            n = $urandom_range(0, 24);
            repeat (n) begin
                k = $urandom_range(0, 19);
                if (k < 2) begin
                    put_byte(CH_PERCENT);
                    put_byte(hex_chars[$urandom_range(0, 21)]);
                    put_byte(hex_chars[$urandom_range(0, 21)]);
                end else if (k == 2) begin
                    put_byte(CH_PERCENT);
                    put_byte(8'($urandom_range(8'h21, 8'h7E)));
                end else if (k == 3) begin
                    put_byte(8'($urandom_range(8'h80, 8'hFF)));
                end else begin
                    put_byte(8'($urandom_range(8'h21, 8'h7E)));
                end
            end
            // truncated escape right before the second space
            if ($urandom_range(0, 9) == 0) put_byte(CH_PERCENT);
            put_byte(CH_SPACE);

            k = $urandom_range(0, 9);
            if (k < 4) begin
                append_text("HTTP/1.1");
            end else if (k < 7) begin
                append_text("HTTP/1.0");
            end else if (k == 7) begin
                append_text("HTTP/1.");
                put_byte(8'($urandom_range(8'h30, 8'h39)));
            end else if (k == 8) begin
                append_text("HTTP/");
                put_byte(8'($urandom_range(8'h30, 8'h39)));
                put_byte(CH_DOT);
                put_byte(8'($urandom_range(8'h30, 8'h39)));
            end else begin
                n = $urandom_range(0, 12);
                repeat (n) put_byte(version_junk[$urandom_range(0, 11)]);
            end
            if ($urandom_range(0, 11) == 0) begin
                n = $urandom_range(1, 8);
                repeat (n) put_byte(version_junk[$urandom_range(0, 11)]);
            end

            if ($urandom_range(0, 5) == 0) begin
                pos = $urandom_range(0, line_buf.size() - 1);
                case ($urandom_range(0, 3))
                    0: line_buf[pos] = 8'($urandom_range(0, 255));
                    1: line_buf.insert(pos, CH_SPACE);
                    2: line_buf.delete(pos);
                    default: line_buf[pos] = 8'($urandom_range(0, 31));
                endcase
            end
        end
        if (line_buf.size() == 0) put_byte(8'($urandom_range(0, 255)));
        flush_line(drain);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sender: offer queued bytes with random gaps
    always @(negedge i_clk) begin : drive_bytes
        t_line_byte nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!i_s_axis_tvalid || in_fire) begin
            if (i_s_axis_tvalid) begin
                tx_gap = tx_burst ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
            end else if (tx_gap > 0) begin
                tx_gap--;
            end
            if (tx_gap == 0 && line_bytes.size() > 0 &&
                    !(line_bytes[0].drain && line_results.size() > 0)) begin
                nxt = line_bytes.pop_front();
                i_s_axis_tdata  <= nxt.data;
                i_s_axis_tlast  <= nxt.last;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: after each transfer hold off ready for a random wait
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_fire) begin
                if (n_results == HOLD_AT_RESULT) rx_wait = LONG_HOLD;
                else rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_m_axis_tready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire  <= i_s_axis_tvalid && o_s_axis_tready;
            out_fire <= o_m_axis_tvalid && i_m_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (step_request_line(i_s_axis_tdata, i_s_axis_tlast, want))
                    line_results = {line_results, want};
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(o_m_axis_tdata[$bits(t_result)-1:0]);
                n_results++;
                if (line_results.size() == 0) begin
                    $error("result with no line pending: %h", got);
                    n_errors++;
                end else begin
                    want = line_results.pop_front();
                    if (got.status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        n_errors++;
                    end
                    if (got.method_code != want.method_code) begin
                        $error("method_code: expected %0d, got %0d",
                               want.method_code, got.method_code);
                        n_errors++;
                    end
                    if (got.version_code != want.version_code) begin
                        $error("version_code: expected %0d, got %0d",
                               want.version_code, got.version_code);
                        n_errors++;
                    end
                    if (got.target_offset != want.target_offset) begin
                        $error("target_offset: expected %0d, got %0d",
                               want.target_offset, got.target_offset);
                        n_errors++;
                    end
                    if (got.target_length != want.target_length) begin
                        $error("target_length: expected %0d, got %0d",
                               want.target_length, got.target_length);
                        n_errors++;
                    end
                end
            end
        end
    end

    // end the run when no transfer happens for too long
    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("http_request_line_checker_top verification failed");
        $finish;
    end

    initial begin : stimulus
        int n_lines;
        clear_request_line();

        append_text("GET / HTTP/1.1");
        flush_line(1'b0);
        put_byte(8'h00);
        flush_line(1'b0);
        put_byte(8'hFF);
        flush_line(1'b0);
        put_byte(CH_DEL);
        flush_line(1'b0);
        append_text("A  B");
        flush_line(1'b0);
        append_text(" X ");
        flush_line(1'b0);

        n_lines = 0;
        while (line_bytes.size() < 24 + RANDOM_BYTES) begin
            queue_random_line(n_lines == 0 || n_lines == DRAIN_AT_LINE);
            n_lines++;
        end
        repeat (10) queue_random_line(1'b0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (line_bytes.size() > 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (line_results.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_errors == 0 && line_results.size() == 0)
            $display("http_request_line_checker_top verification clean");
        else
            $display("http_request_line_checker_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+rtl/core
rtl/core/hrlc_pkg.sv
rtl/core/hrlc_front.sv
rtl/core/hrlc_queue.sv
rtl/core/hrlc_back.sv
rtl/core/http_request_line_checker_top.sv
rtl/core/hrlc_checker.sv
test/tb_http_request_line_checker_top.sv
